// ----- rtl/ipv4dq_pkg.sv -----
// Shared types and character constants for the IPv4 dotted-quad scanner.
package ipv4dq_pkg;

	// Text bytes with a role in the scan
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	// Run length saturates here: a run this long is too long for a later octet
	localparam logic [2:0] RUN_TOO_LONG = 3'd4;
	localparam logic [2:0] RUN_MAX_OK   = 3'd3;

	// Octet limits
	localparam logic [9:0] OCTET_MAX = 10'd255;
	localparam logic [7:0] LOOPBACK  = 8'd127;

	// Number of octets held before the fourth run closes a match
	localparam logic [1:0] LINKS_FULL = 2'd3;

	// Terminator of a digit run
	typedef enum logic [0:0] {
		TERM_OTHER = 1'b0,
		TERM_DOT   = 1'b1
	} term_t;

	// Scan state carried from one item to the next
	typedef struct packed {
		logic [2:0]       run_length;
		logic [11:0]      recent_digits;
		logic [2:0][7:0]  held_octets;
		logic [1:0]       links_held;
		logic             after_dot;
		logic             finished;
	} scan_state_t;

	localparam scan_state_t SCAN_CLEAR = '0;

	// One result item
	typedef struct packed {
		logic       found;
		logic [7:0] octet_a;
		logic [7:0] octet_b;
		logic [7:0] octet_c;
		logic [7:0] octet_d;
	} scan_result_t;

endpackage

// ----- rtl/ipv4dq_step.sv -----
// Per-byte scan step: next scan state and the result item, if any, for one text byte.
module ipv4dq_step (
	input  ipv4dq_pkg::scan_state_t  cur,
	input  logic [7:0]               char_code,
	input  logic                     is_last,
	input  logic                     skip_loopback,
	output ipv4dq_pkg::scan_state_t  nxt,
	output logic                     res_valid,
	output ipv4dq_pkg::scan_result_t res
);

	// Digit run after the current byte is taken in
	logic                    is_digit;
	logic [3:0]              digit_val;
	logic [2:0]              run_len;
	logic [11:0]             digits;
	logic [9:0]              val3;
	logic [9:0]              val2;
	logic                    full;
	logic                    run_ends;
	ipv4dq_pkg::term_t       term;

	always_comb begin
		is_digit  = (char_code inside {[ipv4dq_pkg::CHAR_ZERO:ipv4dq_pkg::CHAR_NINE]});
		digit_val = 4'(char_code - ipv4dq_pkg::CHAR_ZERO);
		if (is_digit) begin
			run_len = (cur.run_length < ipv4dq_pkg::RUN_TOO_LONG) ?
				3'(cur.run_length + 3'd1) : cur.run_length;
			digits  = {cur.recent_digits[7:0], digit_val};
		end else begin
			run_len = cur.run_length;
			digits  = cur.recent_digits;
		end
		// Value of the last three and last two BCD digits
		val2 = 10'(digits[7:4]) * 10'd10 + 10'(digits[3:0]);
		val3 = 10'(digits[11:8]) * 10'd100 + val2;
		full = (run_len != 3'd0) && (run_len <= ipv4dq_pkg::RUN_MAX_OK) &&
			(val3 <= ipv4dq_pkg::OCTET_MAX);
		run_ends = !is_digit || is_last;
		term = (!is_digit && (char_code == ipv4dq_pkg::CHAR_DOT)) ?
			ipv4dq_pkg::TERM_DOT : ipv4dq_pkg::TERM_OTHER;
	end

	// Advance the chain and decide the result
	always_comb begin
		logic got;
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		got       = 1'b0;

		if (cur.finished) begin
			// Drop bytes after a match until the text ends
			if (is_last) begin
				nxt = ipv4dq_pkg::SCAN_CLEAR;
			end
		end else begin
			nxt.run_length    = run_len;
			nxt.recent_digits = digits;
			if (run_ends) begin
				if (cur.after_dot && (cur.links_held == ipv4dq_pkg::LINKS_FULL) && full) begin
					// Fourth octet closes the match
					nxt.held_octets = '0;
					nxt.links_held  = 2'd0;
					nxt.after_dot   = 1'b0;
					if (!(skip_loopback && (cur.held_octets[0] == ipv4dq_pkg::LOOPBACK))) begin
						got         = 1'b1;
						res.found   = 1'b1;
						res.octet_a = cur.held_octets[0];
						res.octet_b = cur.held_octets[1];
						res.octet_c = cur.held_octets[2];
						res.octet_d = val3[7:0];
					end
				end else if (cur.after_dot && (cur.links_held != 2'd0) &&
						(cur.links_held != ipv4dq_pkg::LINKS_FULL) && full &&
						(term == ipv4dq_pkg::TERM_DOT)) begin
					// Link one more octet into the chain
					nxt.held_octets[cur.links_held] = val3[7:0];
					nxt.links_held = 2'(cur.links_held + 2'd1);
				end else begin
					// Break the chain; a run ending at a dot starts a new one
					nxt.held_octets = '0;
					nxt.links_held  = 2'd0;
					nxt.after_dot   = 1'b0;
					if ((term == ipv4dq_pkg::TERM_DOT) && (run_len != 3'd0)) begin
						nxt.held_octets[0] = (val3 <= ipv4dq_pkg::OCTET_MAX) ?
							val3[7:0] : val2[7:0];
						nxt.links_held = 2'd1;
						nxt.after_dot  = 1'b1;
					end
				end
				nxt.run_length    = 3'd0;
				nxt.recent_digits = '0;
			end

			// Report a match, or not-found at text end
			if (got) begin
				res_valid = 1'b1;
				if (is_last) begin
					nxt = ipv4dq_pkg::SCAN_CLEAR;
				end else begin
					nxt.finished = 1'b1;
				end
			end else if (is_last) begin
				res_valid = 1'b1;
				res       = '0;
				nxt       = ipv4dq_pkg::SCAN_CLEAR;
			end
		end
	end

endmodule

// ----- rtl/ipv4dq_regs.sv -----
// Input item register, scan state register and result register with valid/stall control.
module ipv4dq_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               char_code,
	input  logic                     is_last,
	output logic [7:0]               char_s1,
	output logic                     last_s1,
	output ipv4dq_pkg::scan_state_t  state_q,
	input  ipv4dq_pkg::scan_state_t  state_nxt,
	input  logic                     res_valid,
	input  ipv4dq_pkg::scan_result_t res,
	output logic                     out_valid,
	input  logic                     out_stall,
	output ipv4dq_pkg::scan_result_t out_q
);

	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic accept;

	// Step the held item whenever the result register can take a result
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	// Advance the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipv4dq_pkg::SCAN_CLEAR;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && res_valid) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/ipv4_dotted_quad_scanner_top.sv -----
// Top level of the IPv4 dotted-quad scanner.
//
//   channel | signals                             | direction | accepted when
//   --------+-------------------------------------+-----------+----------------------
//   input   | in_valid, in_stall, char_code,      | in        | in_valid && !in_stall
//           | is_last                             |           |
//   output  | out_valid, out_stall, found,        | out       | out_valid && !out_stall
//           | octet_a .. octet_d                  |           |
//   config  | cfg_wr_en, cfg_wr_data              | in        | cfg_wr_en
//
// One byte is accepted every cycle while in_stall is low; the scan step is one pass of logic
// between the input byte register and the result register, so a result is loaded into
// the result register as its byte leaves the input byte register. arst_n clears the scan
// state and sets skip_loopback to 1.
// A stalled result register stalls the input only when a byte is already held.
module ipv4_dotted_quad_scanner_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	output logic [7:0] octet_a,
	output logic [7:0] octet_b,
	output logic [7:0] octet_c,
	output logic [7:0] octet_d
);

	logic                     skip_loopback_q;
	logic [7:0]               char_s1;
	logic                     last_s1;
	ipv4dq_pkg::scan_state_t  state_q;
	ipv4dq_pkg::scan_state_t  state_nxt;
	logic                     res_valid;
	ipv4dq_pkg::scan_result_t res;
	ipv4dq_pkg::scan_result_t out_q;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_loopback_q <= 1'b1;
		end else if (cfg_wr_en) begin
			skip_loopback_q <= cfg_wr_data;
		end
	end

	ipv4dq_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.is_last   (is_last),
		.char_s1   (char_s1),
		.last_s1   (last_s1),
		.state_q   (state_q),
		.state_nxt (state_nxt),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_q     (out_q)
	);

	ipv4dq_step u_step (
		.cur           (state_q),
		.char_code     (char_s1),
		.is_last       (last_s1),
		.skip_loopback (skip_loopback_q),
		.nxt           (state_nxt),
		.res_valid     (res_valid),
		.res           (res)
	);

	// Drive the result fields
	assign found   = out_q.found;
	assign octet_a = out_q.octet_a;
	assign octet_b = out_q.octet_b;
	assign octet_c = out_q.octet_c;
	assign octet_d = out_q.octet_d;

endmodule
